// ----- rtl/arx_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and helpers for the ARX model filter.
// No dependencies; the interfaces and the core import this package.
package arx_pkg;

	localparam int A_ORDER   = 4;
	localparam int B_ORDER   = 4;
	localparam int MAX_DELAY = 15;
	localparam int IN_DEPTH  = B_ORDER + MAX_DELAY;

	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 16;
	localparam int LANES    = 4;
	localparam int CFG_W    = COEF_W * LANES;
	localparam int DT_W     = 4;
	localparam int DLY_W    = $clog2(MAX_DELAY + 2);
	localparam int PROD_W   = SAMPLE_W + COEF_W;
	localparam int ACC_W    = PROD_W + 4;
	localparam int FRAC_SH  = 14;

	localparam logic [CFG_W-1:0] A_COEF_RST    = CFG_W'(58982);
	localparam logic [CFG_W-1:0] B_COEF_RST    = CFG_W'(9830);
	localparam logic [DT_W-1:0]  DEAD_TIME_RST = DT_W'(1);

	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (FRAC_SH - 1));
	localparam logic signed [ACC_W-1:0] SAT_MAX    = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
	localparam logic signed [ACC_W-1:0] SAT_MIN    = -ACC_W'(1 << (SAMPLE_W - 1));

	typedef enum logic [1:0] {
		REG_A_COEF    = 2'd0,
		REG_B_COEF    = 2'd1,
		REG_DEAD_TIME = 2'd2
	} cfg_reg_t;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [ACC_W-1:0]    acc_t;

	function automatic coef_t coef_lane(input logic [CFG_W-1:0] packed_coef, input int k);
		coef_lane = coef_t'(packed_coef[k*COEF_W +: COEF_W]);
	endfunction

endpackage

// ----- rtl/arx_in_if.sv -----
`timescale 1ns / 1ps
// Input sample channel: valid/ready handshake with one signed sample per beat.
// Depends on arx_pkg.
interface arx_in_if import arx_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

// ----- rtl/arx_out_if.sv -----
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with the output sample and clip flag.
// Depends on arx_pkg.
interface arx_out_if import arx_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample_out;
	logic    saturated;

	modport source (output valid, output sample_out, output saturated, input ready);
	modport sink   (input valid, input sample_out, input saturated, output ready);
endinterface

// ----- rtl/arx_model_filter_core.sv -----
`timescale 1ns / 1ps
// ARX difference-equation filter core: configuration registers, histories,
// feed-forward stage and feedback stage. Depends on arx_pkg, arx_in_if, arx_out_if.
//
// channel  dir  payload                       handshake
// in_ch    in   sample_in (s16 Q3.12)          valid/ready
// out_ch   out  sample_out (s16), saturated    valid/ready
// cfg      in   cfg_index, cfg_data (64)       cfg_we, no wait
//
// One sample per cycle sustained while out_ch.ready is high.
// Stage s1 holds the sample, stage s2 the B-tap sum, the output register the
// result; the A-tap feedback loop closes through the output history.
// Each stage advances when its successor is empty or moving, so a stalled
// result does not block intake until the pipeline fills.
// Reset clears both histories, the pipeline valids and loads default coefficients and dead time.
module arx_model_filter_core import arx_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	arx_in_if.sink            in_ch,
	arx_out_if.source         out_ch
);

	logic [CFG_W-1:0] a_coef_q;
	logic [CFG_W-1:0] b_coef_q;
	logic [DT_W-1:0]  dead_time_q;

	sample_t in_hist_q  [IN_DEPTH];
	sample_t out_hist_q [A_ORDER];

	logic    valid_s1;
	sample_t sample_s1;
	logic    valid_s2;
	acc_t    bsum_s2;
	logic    out_valid_q;
	sample_t out_sample_q;
	logic    out_sat_q;

	logic out_adv;
	logic s2_adv;
	logic s1_adv;
	logic s1_move;
	logic s2_move;

	logic [IN_DEPTH*SAMPLE_W-1:0] hist_flat;
	logic [B_ORDER*SAMPLE_W-1:0]  window;
	logic [DLY_W-1:0]             delay;
	acc_t                         bsum;
	acc_t                         acc;
	acc_t                         shifted;
	sample_t                      y;
	logic                         sat;

	assign out_adv = !out_valid_q || out_ch.ready;
	assign s2_adv  = !valid_s2 || out_adv;
	assign s1_adv  = !valid_s1 || s2_adv;
	assign s1_move = valid_s1 && s2_adv;
	assign s2_move = valid_s2 && out_adv;

	assign in_ch.ready       = s1_adv;
	assign out_ch.valid      = out_valid_q;
	assign out_ch.sample_out = out_sample_q;
	assign out_ch.saturated  = out_sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_coef_q    <= A_COEF_RST;
			b_coef_q    <= B_COEF_RST;
			dead_time_q <= DEAD_TIME_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_A_COEF:    a_coef_q    <= cfg_data;
				REG_B_COEF:    b_coef_q    <= cfg_data;
				REG_DEAD_TIME: dead_time_q <= cfg_data[DT_W-1:0];
				default: ;
			endcase
		end
	end

	// shifted input history as seen by the sample in s1
	always_comb begin
		hist_flat[SAMPLE_W-1:0] = sample_s1;
		for (int i = 1; i < IN_DEPTH; i++) begin
			hist_flat[i*SAMPLE_W +: SAMPLE_W] = in_hist_q[i-1];
		end
	end

	assign delay  = (32'(dead_time_q) > MAX_DELAY) ? DLY_W'(MAX_DELAY) : DLY_W'(dead_time_q);
	assign window = hist_flat[delay*SAMPLE_W +: B_ORDER*SAMPLE_W];

	always_comb begin
		logic signed [PROD_W-1:0] p;
		bsum = '0;
		for (int i = 0; i < B_ORDER; i++) begin
			p    = coef_lane(b_coef_q, i) * sample_t'(window[i*SAMPLE_W +: SAMPLE_W]);
			bsum = bsum + ACC_W'(p);
		end
	end

	always_comb begin
		logic signed [PROD_W-1:0] p;
		acc = bsum_s2 + ROUND_HALF;
		for (int i = 0; i < A_ORDER; i++) begin
			p   = coef_lane(a_coef_q, i) * out_hist_q[i];
			acc = acc - ACC_W'(p);
		end
		shifted = acc >>> FRAC_SH;
		if (shifted > SAT_MAX) begin
			y   = sample_t'(SAT_MAX[SAMPLE_W-1:0]);
			sat = 1'b1;
		end else if (shifted < SAT_MIN) begin
			y   = sample_t'(SAT_MIN[SAMPLE_W-1:0]);
			sat = 1'b1;
		end else begin
			y   = sample_t'(shifted[SAMPLE_W-1:0]);
			sat = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < IN_DEPTH; i++) in_hist_q[i] <= '0;
			for (int i = 0; i < A_ORDER; i++) out_hist_q[i] <= '0;
		end else begin
			if (s1_adv) valid_s1 <= in_ch.valid;
			if (s2_adv) valid_s2 <= valid_s1;
			if (out_adv) out_valid_q <= valid_s2;
			if (s1_move) begin
				for (int i = 0; i < IN_DEPTH; i++) begin
					in_hist_q[i] <= sample_t'(hist_flat[i*SAMPLE_W +: SAMPLE_W]);
				end
			end
			if (s2_move) begin
				out_hist_q[0] <= y;
				for (int i = 1; i < A_ORDER; i++) out_hist_q[i] <= out_hist_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && in_ch.valid) sample_s1 <= in_ch.sample_in;
		if (s1_move) bsum_s2 <= bsum;
		if (s2_move) begin
			out_sample_q <= y;
			out_sat_q    <= sat;
		end
	end

endmodule

// ----- bench/arx_model_filter_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for arx_model_filter_core: drives sample beats and
// register writes, predicts each output beat in place.
// Depends on arx_pkg and both channel interfaces.
module arx_model_filter_core_tb import arx_pkg::*; ();

	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 6;

	typedef struct packed {
		sample_t value;
		logic    clipped;
	} arx_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [1:0]           cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	arx_in_if  in_ch();
	arx_out_if out_ch();

	arx_model_filter_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// filter state as the block should hold it
	logic [CFG_W-1:0] a_reg;
	logic [CFG_W-1:0] b_reg;
	logic [DT_W-1:0]  dt_reg;
	sample_t          in_hist  [IN_DEPTH];
	sample_t          out_hist [A_ORDER];

	arx_result_t pending_outputs[$];
	int          fails;
	int          stall_cycles;
	int          hold_request;
	bit          idle_on;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic arx_result_t arx_predict(input sample_t x);
		arx_result_t r;
		longint      acc;
		longint      y;
		int          d;
		int          i;
		acc = 0;
		for (i = IN_DEPTH - 1; i > 0; i--)
			in_hist[i] = in_hist[i-1];
		in_hist[0] = x;
		d = (dt_reg > MAX_DELAY) ? MAX_DELAY : int'(dt_reg);
		for (i = 0; i < B_ORDER; i++)
			acc += longint'($signed(b_reg[i*COEF_W +: COEF_W])) * longint'(in_hist[i+d]);
		for (i = 0; i < A_ORDER; i++)
			acc -= longint'($signed(a_reg[i*COEF_W +: COEF_W])) * longint'(out_hist[i]);
		y = (acc + longint'(1 << (FRAC_SH - 1))) >>> FRAC_SH;
		r.clipped = 1'b0;
		if (y > 32767) begin
			y = 32767;
			r.clipped = 1'b1;
		end else if (y < -32768) begin
			y = -32768;
			r.clipped = 1'b1;
		end
		r.value = sample_t'(y);
		for (i = A_ORDER - 1; i > 0; i--)
			out_hist[i] = out_hist[i-1];
		out_hist[0] = r.value;
		return r;
	endfunction

	function automatic logic [CFG_W-1:0] pick_coefs(input int mode);
		logic [CFG_W-1:0] c;
		int               k;
		c = '0;
		for (k = 0; k < LANES; k++) begin
			case (mode)
				0: c[k*COEF_W +: COEF_W] = 16'($urandom_range(0, 65535));
				1, 2: c[k*COEF_W +: COEF_W] = 16'($signed($urandom_range(0, 4096)) - 2048);
				3: case ($urandom_range(0, 3))
					0: c[k*COEF_W +: COEF_W] = 16'h7FFF;
					1: c[k*COEF_W +: COEF_W] = 16'h8000;
					2: c[k*COEF_W +: COEF_W] = 16'hFFFF;
					default: c[k*COEF_W +: COEF_W] = 16'h0000;
				endcase
				default: c[k*COEF_W +: COEF_W] = 16'h0000;
			endcase
		end
		return c;
	endfunction

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 9))
			0: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
			1, 2: return sample_t'($signed($urandom_range(0, 1024)) - 512);
			default: return sample_t'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic send_sample(input sample_t s);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.sample_in <= s;
		do @(posedge clk); while (!in_ch.ready);
		pending_outputs.push_back(arx_predict(s));
	endtask

	// drop valid, drain all outstanding beats, then let the pipeline empty
	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [CFG_W-1:0] a, input logic [CFG_W-1:0] b,
			input logic [DT_W-1:0] dt);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_A_COEF;
		cfg_data  <= a;
		@(posedge clk);
		cfg_index <= REG_B_COEF;
		cfg_data  <= b;
		@(posedge clk);
		cfg_index <= REG_DEAD_TIME;
		cfg_data  <= CFG_W'(dt);
		@(posedge clk);
		cfg_we <= 1'b0;
		a_reg  = a;
		b_reg  = b;
		dt_reg = dt;
	endtask

	task automatic test_reset_defaults();
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(16'sh0000);
		send_sample(16'sh1000);
		send_sample(-16'sd1);
	endtask

	task automatic test_saturation();
		configure('0, {4{16'h7FFF}}, 4'd0);
		send_sample(16'sh7FFF);
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(16'sh8000);
		configure({4{16'h8000}}, {16'h0000, 16'h0000, 16'h8000, 16'h7FFF}, 4'd0);
		send_sample(16'sh8000);
		send_sample(16'sh7FFF);
		send_sample(16'sh0001);
	endtask

	// grow the delay after the history has filled; old samples must reappear
	task automatic test_dead_time();
		logic [CFG_W-1:0] b;
		int               i;
		b = {16'h1000, 16'h2000, 16'h3000, 16'h4000};
		configure('0, b, 4'd15);
		for (i = 0; i < 6; i++)
			send_sample(pick_sample());
		configure('0, b, 4'd0);
		for (i = 0; i < 3; i++)
			send_sample(pick_sample());
		configure({{3{16'h0000}}, 16'hE000}, b, 4'd15);
		for (i = 0; i < 3; i++)
			send_sample(pick_sample());
	endtask

	task automatic test_random_phases();
		logic [DT_W-1:0] dt;
		int              p;
		int              i;
		for (p = 0; p < 10; p++) begin
			case (p)
				0: dt = 4'd0;
				1: dt = 4'd15;
				default: dt = DT_W'($urandom_range(0, 15));
			endcase
			if (p == 1)
				configure(pick_coefs(3), pick_coefs(3), dt);
			else
				configure(pick_coefs($urandom_range(0, 4)), pick_coefs($urandom_range(0, 3)), dt);
			for (i = 0; i < 40; i++)
				send_sample(pick_sample());
		end
	endtask

	// hold the result side long enough that the pipeline fills and intake stalls
	task automatic test_backpressure();
		int i;
		configure(pick_coefs(1), pick_coefs(1), DT_W'($urandom_range(0, 15)));
		idle_on      = 1'b0;
		hold_request = 60;
		for (i = 0; i < 40; i++)
			send_sample(pick_sample());
		idle_on = 1'b1;
	endtask

	task automatic test_full_rate();
		int i;
		configure(pick_coefs(1), pick_coefs(0), DT_W'($urandom_range(0, 15)));
		idle_on = 1'b0;
		for (i = 0; i < 100; i++)
			send_sample(pick_sample());
	endtask

	initial begin : sink_side
		int n;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				n            = hold_request;
				hold_request = 0;
				out_ch.ready <= 1'b0;
				repeat (n - 1) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 6) - 1) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_outputs
		arx_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_outputs.size() == 0) begin
				$display("%0t: unexpected output beat, sample_out %0d saturated %0b",
					$time, out_ch.sample_out, out_ch.saturated);
				fails++;
			end else begin
				want = pending_outputs.pop_front();
				if (out_ch.sample_out !== want.value) begin
					$display("%0t: sample_out expected %0d actual %0d",
						$time, want.value, out_ch.sample_out);
					fails++;
				end
				if (out_ch.saturated !== want.clipped) begin
					$display("%0t: saturated expected %0b actual %0b",
						$time, want.clipped, out_ch.saturated);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int i;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = REG_A_COEF;
		cfg_data        = '0;
		in_ch.valid     = 1'b0;
		in_ch.sample_in = '0;
		fails           = 0;
		stall_cycles    = 0;
		hold_request    = 0;
		idle_on         = 1'b1;
		a_reg           = A_COEF_RST;
		b_reg           = B_COEF_RST;
		dt_reg          = DEAD_TIME_RST;
		for (i = 0; i < IN_DEPTH; i++)
			in_hist[i] = '0;
		for (i = 0; i < A_ORDER; i++)
			out_hist[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_saturation();
		test_dead_time();
		test_random_phases();
		test_backpressure();
		test_full_rate();
		settle();

		if (fails == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/arx_pkg.sv
rtl/arx_in_if.sv
rtl/arx_out_if.sv
rtl/arx_model_filter_core.sv
bench/arx_model_filter_core_tb.sv
